// ----- hw/rtl/txr_pkg.sv -----
// ----------------------------------------------------------------------------
// txr_pkg: shared types for the torus XY router node
// Beat payloads for the input and result channels, port codes.
// ----------------------------------------------------------------------------
package txr_pkg;

    typedef struct packed {
        logic        hold;
        logic [31:0] local_dest;
        logic        local_valid;
        logic [31:0] left_dest;
        logic        left_valid;
        logic [31:0] up_dest;
        logic        up_valid;
        logic        eject_blocked;
        logic        right_blocked;
        logic        down_blocked;
    } txr_in_t;

    typedef struct packed {
        logic [31:0] eject_dest;
        logic        eject_valid;
        logic [31:0] right_dest;
        logic        right_valid;
        logic [31:0] down_dest;
        logic        down_valid;
        logic        local_full;
        logic        left_full;
        logic        up_full;
        logic        overflow;
    } txr_out_t;

    localparam logic [1:0] PORT_EJ = 2'd0;
    localparam logic [1:0] PORT_RT = 2'd1;
    localparam logic [1:0] PORT_DN = 2'd2;

    localparam logic REG_COLUMN = 1'b0;
    localparam logic REG_ROW    = 1'b1;

    localparam int LOCAL_SLACK = 6;

endpackage

// ----- hw/rtl/txr_in_if.sv -----
// ----------------------------------------------------------------------------
// txr_in_if: input beat channel
// Valid/ready handshake carrying one input beat.
// ----------------------------------------------------------------------------
interface txr_in_if import txr_pkg::*;;
    logic    valid;
    logic    ready;
    txr_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/txr_out_if.sv -----
// ----------------------------------------------------------------------------
// txr_out_if: result beat channel
// Valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface txr_out_if import txr_pkg::*;;
    logic     valid;
    logic     ready;
    txr_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/torus_xy_router_node.sv -----
// ----------------------------------------------------------------------------
// torus_xy_router_node: one node of a unidirectional 2D torus, XY routing
// Nine input-by-output FIFOs in nine storage banks, counters in flip-flops.
// ----------------------------------------------------------------------------
// A new input beat is taken every cycle unless the result beat is stalled;
// each result beat is registered and appears in the cycle after acceptance.
// Input ready follows the result register only (a beat is taken whenever
// the result register is empty or drained in the same cycle). Each of the
// nine queues has its own storage bank with one write port (its input) and
// one registered read port; heads are read ahead and forwarded when the head
// entry is written in the same cycle, and a flit that arrives at an empty
// local or left eject queue can leave as it arrives. No clearing pass after reset.
module torus_xy_router_node
    import txr_pkg::*;
#(
    parameter int GRID_X      = 4,
    parameter int GRID_Y      = 4,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [1:0]       cfg_data,
    txr_in_if.sink           in_ch,
    txr_out_if.source        out_ch
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NODES = GRID_X * GRID_Y;
    localparam logic [CW-1:0] LIM_FULL = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] LIM_LOC  = CW'(QUEUE_DEPTH - LOCAL_SLACK);

    logic [1:0] col_reg, row_reg;
    logic [CW-1:0] cnt_reg [9];
    logic [AW-1:0] head_reg [9];
    logic [AW-1:0] tail_reg [9];

    logic     ovalid_reg;
    txr_out_t odata_reg;
    logic     accept;

    assign in_ch.ready = !ovalid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COLUMN)
                col_reg <= cfg_data;
            else
                row_reg <= cfg_data;
        end
    end

    function automatic logic [1:0] route(input logic [31:0] id, input logic [1:0] c,
                                         input logic [1:0] r);
        logic [31:0] cc, rr;
        cc = id % GRID_X;
        rr = (id % NODES) / GRID_X;
        if (cc != {30'd0, c})
            return PORT_RT;
        else if (rr != {30'd0, r})
            return PORT_DN;
        else
            return PORT_EJ;
    endfunction

    // combinational step
    logic [31:0] sdest [3];
    logic        svalid [3];
    logic [1:0]  sport [3];
    logic        push [9];
    logic        pop [9];
    logic [CW-1:0] cnt_a [9];
    logic [CW-1:0] cnt_n [9];
    logic        ovf;
    logic [3:0]  ej_q, rt_q, dn_q;
    logic        ev, rv, dv;
    logic [31:0] hd [9];
    logic [2:0]  fl;

    always_comb
    begin
        sdest[0] = in_ch.data.local_dest;  svalid[0] = in_ch.data.local_valid;
        sdest[1] = in_ch.data.left_dest;   svalid[1] = in_ch.data.left_valid;
        sdest[2] = in_ch.data.up_dest;     svalid[2] = in_ch.data.up_valid;
        ovf = 1'b0;
        for (int q = 0; q < 9; q++)
        begin
            push[q] = 1'b0;
            pop[q]  = 1'b0;
        end
        for (int s = 0; s < 3; s++)
        begin
            sport[s] = route(sdest[s], col_reg, row_reg);
            if (!in_ch.data.hold && svalid[s])
            begin
                if (cnt_reg[s*3 + int'(sport[s])] == LIM_FULL)
                    ovf = 1'b1;
                else
                    push[s*3 + int'(sport[s])] = 1'b1;
            end
        end
        for (int q = 0; q < 9; q++)
            cnt_a[q] = cnt_reg[q] + CW'(push[q]);

        ev = 1'b0; rv = 1'b0; dv = 1'b0;
        ej_q = 4'd0; rt_q = 4'd1; dn_q = 4'd2;
        if (!in_ch.data.hold && !in_ch.data.eject_blocked)
        begin
            if (cnt_a[0] > cnt_a[3] && cnt_a[0] > cnt_a[6])
            begin
                ev = 1'b1; ej_q = 4'd0;
            end
            else if (cnt_a[3] > cnt_a[6])
            begin
                ev = 1'b1; ej_q = 4'd3;
            end
            else if (cnt_reg[6] != '0)
            begin
                ev = 1'b1; ej_q = 4'd6;
            end
        end
        if (!in_ch.data.hold && !in_ch.data.right_blocked)
        begin
            if (cnt_reg[4] != '0)
            begin
                rv = 1'b1; rt_q = 4'd4;
            end
            else if (cnt_reg[7] != '0)
            begin
                rv = 1'b1; rt_q = 4'd7;
            end
            else if (cnt_reg[1] != '0)
            begin
                rv = 1'b1; rt_q = 4'd1;
            end
        end
        if (!in_ch.data.hold && !in_ch.data.down_blocked)
        begin
            if (cnt_reg[8] != '0)
            begin
                dv = 1'b1; dn_q = 4'd8;
            end
            else if (cnt_reg[5] != '0)
            begin
                dv = 1'b1; dn_q = 4'd5;
            end
            else if (cnt_reg[2] != '0)
            begin
                dv = 1'b1; dn_q = 4'd2;
            end
        end
        pop[ej_q] = ev;
        pop[rt_q] = rv;
        pop[dn_q] = dv;
        for (int q = 0; q < 9; q++)
            cnt_n[q] = cnt_a[q] - CW'(pop[q]);
        fl = 3'b000;
        for (int q = 0; q < 9; q++)
        begin
            if (q < 3)
                fl[0] = fl[0] | (cnt_n[q] >= LIM_LOC);
            else
                fl[q/3] = fl[q/3] | (cnt_n[q] == LIM_FULL);
        end
    end

    logic [AW-1:0] head_n [9];

    always_comb
    begin
        for (int q = 0; q < 9; q++)
        begin
            head_n[q] = head_reg[q] + AW'(pop[q]);
            if (head_n[q] == AW'(QUEUE_DEPTH) && pop[q])
                head_n[q] = '0;
        end
    end

    // storage: one bank per queue, written at the tail, head pre-read for next cycle
    for (genvar q = 0; q < 9; q++)
    begin : g_bank
        logic [31:0]   mem [QUEUE_DEPTH];
        logic [AW-1:0] rd_addr;
        logic [31:0]   hrd_reg;
        logic          hbyp_reg;
        logic [31:0]   hbd_reg;

        assign rd_addr = accept ? head_n[q] : head_reg[q];

        always_ff @(posedge clk)
        begin
            if (accept && push[q])
                mem[tail_reg[q]] <= sdest[q/3];
            hrd_reg  <= mem[rd_addr];
            hbyp_reg <= accept && push[q] && (tail_reg[q] == rd_addr);
            hbd_reg  <= sdest[q/3];
        end

        // empty queue: only a flit arriving this beat can leave
        assign hd[q] = (cnt_reg[q] == '0) ? sdest[q/3]
                       : (hbyp_reg ? hbd_reg : hrd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < 9; q++)
            begin
                cnt_reg[q]  <= '0;
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
            end
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (accept)
            begin
                ovalid_reg <= 1'b1;
                for (int q = 0; q < 9; q++)
                begin
                    cnt_reg[q]  <= cnt_n[q];
                    head_reg[q] <= head_n[q];
                    if (push[q])
                        tail_reg[q] <= (int'(tail_reg[q]) == QUEUE_DEPTH - 1) ? '0
                                       : tail_reg[q] + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            odata_reg.eject_dest  <= ev ? hd[ej_q] : 32'd0;
            odata_reg.eject_valid <= ev;
            odata_reg.right_dest  <= rv ? hd[rt_q] : 32'd0;
            odata_reg.right_valid <= rv;
            odata_reg.down_dest   <= dv ? hd[dn_q] : 32'd0;
            odata_reg.down_valid  <= dv;
            odata_reg.local_full  <= fl[0];
            odata_reg.left_full   <= fl[1];
            odata_reg.up_full     <= fl[2];
            odata_reg.overflow    <= ovf;
        end
    end

endmodule

// ----- hw/rtl/txr_checker.sv -----
// ----------------------------------------------------------------------------
// txr_checker: port-level checks on the router node
// Result beat consistency and handshake behaviour.
// ----------------------------------------------------------------------------
module txr_checker
    import txr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input txr_out_t out_data
);

    a_ej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.eject_valid |-> out_data.eject_dest == '0)
        else $error("eject dest not zero");

    a_rt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.right_valid |-> out_data.right_dest == '0)
        else $error("right dest not zero");

    a_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result beat missing");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

endmodule

bind torus_xy_router_node txr_checker u_txr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
